// ----- rtl/core/tmsf_pkg.sv -----
// shared types and constants for the trimmed mean step filter
`timescale 1ns / 1ps

package tmsf_pkg;

    localparam int SAMPLE_W = 24;
    localparam int GAP_W    = 23;

    localparam logic [GAP_W-1:0] GAP_RESET = 23'd150;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // from a cell to the cell above it
    typedef struct packed {
        logic    del_incl;
        logic    le;
        sample_t lval;
    } up_link_t;

    // from a cell to the cell below it
    typedef struct packed {
        logic    present;
        sample_t val;
    } down_link_t;

endpackage

// ----- rtl/core/tmsf_cell.sv -----
// one sorted cell: holds a value with its age and one partial sum stage
`timescale 1ns / 1ps

module tmsf_cell #(
    parameter int          AGE_W   = 2,
    parameter int          SUM_W   = 26,
    parameter int          INDEX   = 0,
    parameter int          OLD_AGE = 3,
    parameter bit          KEEP_ME = 1'b0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  logic                  fill,
    input  tmsf_pkg::sample_t     sample,
    input  tmsf_pkg::up_link_t    below_in,
    input  logic [AGE_W-1:0]      below_lage,
    input  logic [SUM_W-1:0]      below_psum,
    input  tmsf_pkg::down_link_t  above_in,
    input  logic [AGE_W-1:0]      above_age,
    output tmsf_pkg::up_link_t    up_out,
    output logic [AGE_W-1:0]      up_lage,
    output logic [SUM_W-1:0]      up_psum,
    output tmsf_pkg::down_link_t  down_out,
    output logic [AGE_W-1:0]      down_age
);

    tmsf_pkg::sample_t  value_reg, value_next;
    logic [AGE_W-1:0]   age_reg, age_next;
    logic [SUM_W-1:0]   psum_reg, psum_next;

    logic               del_incl;
    logic               lexist;
    logic               le;
    tmsf_pkg::sample_t  lval;
    logic [AGE_W-1:0]   lage;

    // entry this cell holds once the oldest entry is taken out
    always_comb begin
        del_incl = below_in.del_incl | (age_reg == OLD_AGE[AGE_W-1:0]);
        lval     = del_incl ? above_in.val : value_reg;
        lage     = AGE_W'((del_incl ? above_age : age_reg) + 1'b1);
        lexist   = !del_incl || above_in.present;
        le       = lexist && (lval <= sample);
    end

    always_comb begin
        value_next = value_reg;
        age_next   = age_reg;
        if (fill) begin
            value_next = sample;
        end else if (load) begin
            if (le) begin
                value_next = lval;
                age_next   = lage;
            end else if (below_in.le) begin
                value_next = sample;
                age_next   = '0;
            end else begin
                value_next = below_in.lval;
                age_next   = below_lage;
            end
        end
    end

    always_comb begin
        if (KEEP_ME) begin
            psum_next = below_psum
                      + {{(SUM_W-tmsf_pkg::SAMPLE_W){value_reg[tmsf_pkg::SAMPLE_W-1]}},
                         value_reg};
        end else begin
            psum_next = below_psum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
            age_reg   <= AGE_W'(INDEX);
        end else begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

    always_ff @(posedge aclk) begin
        psum_reg <= psum_next;
    end

    assign up_out.del_incl = del_incl;
    assign up_out.le       = le;
    assign up_out.lval     = lval;
    assign up_lage         = lage;
    assign up_psum         = psum_reg;
    assign down_out.present = 1'b1;
    assign down_out.val     = value_reg;
    assign down_age         = age_reg;

endmodule

// ----- rtl/core/tmsf_div.sv -----
// divider of a signed sum by the constant keep count through a reciprocal multiply
`timescale 1ns / 1ps

module tmsf_div #(
    parameter int SUM_W = 26,
    parameter int KEEP  = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [SUM_W-1:0]   dividend,
    output logic               done,
    output tmsf_pkg::sample_t  quotient
);

    localparam int SH = SUM_W + $clog2(KEEP);
    localparam int PW = 2 * SUM_W + 1;
    localparam logic [SUM_W:0] RECIP =
        (SUM_W + 1)'(((64'd1 << SH) + 64'(KEEP - 1)) / 64'(KEEP));

    logic               mul_go_reg;
    logic               done_reg;
    logic               neg_reg;
    logic               neg2_reg;
    logic [SUM_W-1:0]   mag_reg;
    logic [PW-1:0]      prod_reg;

    logic [SUM_W-1:0]   mag;
    logic [PW-1:0]      prod;
    tmsf_pkg::sample_t  q_mag;

    always_comb begin
        mag   = dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
        prod  = PW'(mag_reg) * PW'(RECIP);
        q_mag = prod_reg[SH +: tmsf_pkg::SAMPLE_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_go_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            mul_go_reg <= start;
            done_reg   <= mul_go_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mag_reg <= mag;
            neg_reg <= dividend[SUM_W-1];
        end
        if (mul_go_reg) begin
            prod_reg <= prod;
            neg2_reg <= neg_reg;
        end
    end

    assign done     = done_reg;
    assign quotient = neg2_reg ? -q_mag : q_mag;

endmodule

// ----- rtl/core/trimmed_mean_step_filter.sv -----
// Trimmed mean step filter. Each input beat is a signed 24 bit thickness sample; each
// output beat gives the mean of the KEEP sorted window values after the TRIM_LOW
// smallest (truncated toward zero), or the sample itself with m_step_seen set when two
// changes of at least gap_threshold in the same direction are seen, in which case the
// whole window is refilled with that sample. The window lives in a row of WINDOW sorted
// cells that take out the oldest entry and insert the new one in the same cycle. A step
// beat goes straight to the result state with the sample as its result. Any other beat
// takes these steps after acceptance: the partial sum ripples through the row of cells
// one cell per cycle, then the magnitude of the sum is registered, multiplied by a
// reciprocal of KEEP, the quotient latched and the output register loaded. For either
// kind the input opens again when the output register is loaded. One sample is
// processed at a time; the next is accepted while the previous result still waits on
// the output, and a finished result waits for the output register to free before the
// input opens again.
`timescale 1ns / 1ps

module trimmed_mean_step_filter #(
    parameter int WINDOW   = 4,
    parameter int TRIM_LOW = 1,
    parameter int KEEP     = 2
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [tmsf_pkg::GAP_W-1:0]    cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  tmsf_pkg::sample_t             s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output tmsf_pkg::sample_t             m_filtered,
    output logic                          m_step_seen
);

    localparam int AGE_W = $clog2(WINDOW);
    localparam int SUM_W = tmsf_pkg::SAMPLE_W + $clog2(KEEP) + 1;
    localparam int CNT_W = $clog2(WINDOW);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SUM   = 3'd1;
    localparam logic [2:0] ST_DGO   = 3'd2;
    localparam logic [2:0] ST_DWAIT = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]                    state_reg, state_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [tmsf_pkg::GAP_W-1:0]    gap_reg;
    tmsf_pkg::sample_t             prev_reg, prev_next;
    tmsf_pkg::sample_t             prev2_reg, prev2_next;
    tmsf_pkg::sample_t             res_reg, res_next;
    logic                          res_step_reg, res_step_next;
    logic                          m_valid_reg, m_valid_next;
    tmsf_pkg::sample_t             m_filtered_reg, m_filtered_next;
    logic                          m_step_reg, m_step_next;

    logic                          accept;
    logic                          step;
    logic                          rise;
    logic signed [24:0]            diff;
    logic signed [24:0]            mag;
    logic signed [24:0]            diff2;
    logic signed [24:0]            gap_ext;
    logic                          out_free;

    logic                          div_start;
    logic                          div_done;
    tmsf_pkg::sample_t             div_quot;

    tmsf_pkg::up_link_t            up_link [WINDOW+1];
    logic [AGE_W-1:0]              up_lage [WINDOW+1];
    logic [SUM_W-1:0]              up_psum [WINDOW+1];
    tmsf_pkg::down_link_t          dn_link [WINDOW+1];
    logic [AGE_W-1:0]              dn_age  [WINDOW+1];

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // step test against the two most recent samples
    always_comb begin
        gap_ext = {2'b00, gap_reg};
        diff    = 25'(s_sample) - 25'(prev_reg);
        mag     = diff[24] ? -diff : diff;
        rise    = (s_sample > prev_reg);
        diff2   = rise ? 25'(prev_reg) - 25'(prev2_reg)
                       : 25'(prev2_reg) - 25'(prev_reg);
        step    = (mag >= gap_ext) && (diff2 >= gap_ext);
    end

    assign up_link[0].del_incl = 1'b0;
    assign up_link[0].le       = 1'b1;
    assign up_link[0].lval     = '0;
    assign up_lage[0]          = '0;
    assign up_psum[0]          = '0;
    assign dn_link[WINDOW].present = 1'b0;
    assign dn_link[WINDOW].val     = '0;
    assign dn_age[WINDOW]          = '0;

    for (genvar i = 0; i < WINDOW; i++) begin : g_cell
        tmsf_cell #(
            .AGE_W   (AGE_W),
            .SUM_W   (SUM_W),
            .INDEX   (i),
            .OLD_AGE (WINDOW - 1),
            .KEEP_ME ((i >= TRIM_LOW) && (i < TRIM_LOW + KEEP))
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .load       (accept && !step),
            .fill       (accept && step),
            .sample     (s_sample),
            .below_in   (up_link[i]),
            .below_lage (up_lage[i]),
            .below_psum (up_psum[i]),
            .above_in   (dn_link[i+1]),
            .above_age  (dn_age[i+1]),
            .up_out     (up_link[i+1]),
            .up_lage    (up_lage[i+1]),
            .up_psum    (up_psum[i+1]),
            .down_out   (dn_link[i]),
            .down_age   (dn_age[i])
        );
    end

    assign div_start = (state_reg == ST_DGO);

    tmsf_div #(
        .SUM_W (SUM_W),
        .KEEP  (KEEP)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (up_psum[WINDOW]),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        prev_next       = prev_reg;
        prev2_next      = prev2_reg;
        res_next        = res_reg;
        res_step_next   = res_step_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_filtered_next = m_filtered_reg;
        m_step_next     = m_step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (step) begin
                        prev_next     = s_sample;
                        prev2_next    = s_sample;
                        res_next      = s_sample;
                        res_step_next = 1'b1;
                        state_next    = ST_DONE;
                    end else begin
                        prev_next     = s_sample;
                        prev2_next    = prev_reg;
                        res_step_next = 1'b0;
                        cnt_next      = '0;
                        state_next    = ST_SUM;
                    end
                end
            end
            ST_SUM: begin
                if (cnt_reg == CNT_W'(WINDOW - 1)) begin
                    state_next = ST_DGO;
                end else begin
                    cnt_next = CNT_W'(cnt_reg + 1'b1);
                end
            end
            ST_DGO: begin
                state_next = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (div_done) begin
                    res_next   = div_quot;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_filtered_next = res_reg;
                    m_step_next     = res_step_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            gap_reg     <= tmsf_pkg::GAP_RESET;
            prev_reg    <= '0;
            prev2_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            prev_reg    <= prev_next;
            prev2_reg   <= prev2_next;
            if (cfg_wr_en) begin
                gap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg        <= cnt_next;
        res_reg        <= res_next;
        res_step_reg   <= res_step_next;
        m_filtered_reg <= m_filtered_next;
        m_step_reg     <= m_step_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_filtered  = m_filtered_reg;
    assign m_step_seen = m_step_reg;

    a_accept_leaves_idle: assert property (
        @(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_SUM) || (state_reg == ST_DONE)
    ) else $error("accepted beat did not start processing");

    a_step_result_is_sample: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) && res_step_reg |-> (res_reg == prev_reg)
    ) else $error("step result differs from latest sample");

    a_step_goes_done: assert property (
        @(posedge aclk) disable iff (!aresetn)
        accept && step |=> (state_reg == ST_DONE) && res_step_reg
                           && (prev_reg == prev2_reg)
    ) else $error("step beat not handled as refill");

    a_output_from_done: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(state_reg) == ST_DONE)
    ) else $error("output beat raised outside result state");

endmodule

// ----- sim/trimmed_mean_step_filter_tb.sv -----
// self-checking testbench for the trimmed mean step filter with a sample-window model
`timescale 1ns / 1ps

module trimmed_mean_step_filter_tb;

    localparam int WINDOW = 4;
    localparam int TRIM_LOW = 1;
    localparam int KEEP = 2;
    localparam longint SMIN = -8388608;
    localparam longint SMAX = 8388607;
    localparam int DRAIN_CYCLES = 40;

    typedef tmsf_pkg::sample_t sample_t;
    typedef logic [tmsf_pkg::GAP_W-1:0] gap_t;

    localparam gap_t GAP_MAX = '1;

    typedef struct {
        sample_t filtered;
        logic    step_seen;
    } filt_out_t;

    logic    aclk;
    logic    aresetn;
    logic    cfg_wr_en;
    gap_t    cfg_wr_data;
    logic    s_valid;
    logic    s_ready;
    sample_t s_sample;
    logic    m_valid;
    logic    m_ready;
    sample_t m_filtered;
    logic    m_step_seen;

    // window model
    sample_t     win_model[WINDOW];
    int unsigned next_slot;
    gap_t        gap_model;

    filt_out_t mean_queue[$];
    int        errors = 0;
    int        beats_sent = 0;
    int        results_seen = 0;
    int        steps_seen = 0;
    int        gap_writes = 0;
    bit        src_idle_on = 1'b1;
    bit        snk_idle_on = 1'b1;
    int        hold_len = 0;
    int        stall_left = 0;

    trimmed_mean_step_filter #(
        .WINDOW   (WINDOW),
        .TRIM_LOW (TRIM_LOW),
        .KEEP     (KEEP)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_filtered  (m_filtered),
        .m_step_seen (m_step_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic filt_out_t filter_sample(input sample_t x);
        longint    xv;
        longint    pv;
        longint    p2v;
        longint    g;
        longint    diff;
        longint    mag;
        longint    acc;
        longint    t;
        longint    srt[WINDOW];
        bit        jump;
        filt_out_t r;
        xv = x;
        pv = win_model[(next_slot + WINDOW - 1) % WINDOW];
        p2v = win_model[(next_slot + WINDOW - 2) % WINDOW];
        g = gap_model;
        diff = xv - pv;
        mag = (diff < 0) ? -diff : diff;
        jump = 1'b0;
        if (mag >= g) begin
            jump = (xv > pv) ? (pv - p2v >= g) : (p2v - pv >= g);
        end
        if (jump) begin
            foreach (win_model[i]) win_model[i] = x;
            r.filtered = x;
            r.step_seen = 1'b1;
            return r;
        end
        win_model[next_slot] = x;
        next_slot = (next_slot + 1) % WINDOW;
        foreach (win_model[i]) srt[i] = win_model[i];
        for (int i = 0; i < WINDOW - 1; i++) begin
            for (int j = 0; j < WINDOW - 1 - i; j++) begin
                if (srt[j] > srt[j + 1]) begin
                    t = srt[j];
                    srt[j] = srt[j + 1];
                    srt[j + 1] = t;
                end
            end
        end
        acc = 0;
        for (int k = TRIM_LOW; k < TRIM_LOW + KEEP; k++) begin
            if (k < WINDOW) acc += srt[k];
        end
        r.filtered = sample_t'(acc / KEEP);
        r.step_seen = 1'b0;
        return r;
    endfunction

    function automatic sample_t clamp_sample(input longint v);
        if (v < SMIN) return sample_t'(SMIN);
        if (v > SMAX) return sample_t'(SMAX);
        return sample_t'(v);
    endfunction

    function automatic longint jitter(input longint span);
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int pick_idle();
        int r;
        if (!src_idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_sample(input sample_t x);
        int idle;
        idle = pick_idle();
        if (idle > 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= x;
        do @(posedge aclk); while (!s_ready);
        mean_queue.push_back(filter_sample(x));
        beats_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (mean_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_gap(input gap_t g);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= g;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        gap_model = g;
        gap_writes++;
    endtask

    // result side backpressure
    always @(posedge aclk) begin : drive_ready
        int r;
        if (hold_len > 0) begin
            m_ready <= 1'b0;
            hold_len--;
        end else if (!snk_idle_on) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                m_ready <= 1'b1;
            end else if (r < 96) begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end else begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(15, 60);
            end
        end
    end

    always @(posedge aclk) begin : check_results
        filt_out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_step_seen) steps_seen++;
            if (mean_queue.size() == 0) begin
                $error("result beat with nothing pending: filtered %0d step_seen %0b",
                       m_filtered, m_step_seen);
                errors++;
            end else begin
                want = mean_queue.pop_front();
                if (m_filtered !== want.filtered) begin
                    $error("filtered: expected %0d, got %0d", want.filtered, m_filtered);
                    errors++;
                end
                if (m_step_seen !== want.step_seen) begin
                    $error("step_seen: expected %0b, got %0b", want.step_seen, m_step_seen);
                    errors++;
                end
            end
        end
    end

    // reset value of the threshold, rising and falling steps, near misses
    task automatic test_reset_threshold();
        send_sample(sample_t'(0));
        send_sample(sample_t'(149));
        send_sample(sample_t'(300));
        send_sample(sample_t'(500));
        send_sample(sample_t'(300));
        send_sample(sample_t'(100));
    endtask

    // threshold and sample extremes, equal samples with a zero threshold
    task automatic test_extremes();
        drain();
        set_gap('0);
        send_sample(sample_t'(0));
        send_sample(sample_t'(0));
        send_sample(sample_t'(SMIN));
        send_sample(sample_t'(SMAX));
        send_sample(sample_t'(SMAX));
        send_sample(sample_t'(SMIN));
        send_sample(sample_t'(1));
        send_sample(sample_t'(-1));
        drain();
        set_gap(GAP_MAX);
        send_sample(sample_t'(SMIN));
        send_sample(sample_t'(SMIN));
        send_sample(sample_t'(-1));
        send_sample(sample_t'(SMAX - 1));
        send_sample(sample_t'(SMAX));
        send_sample(sample_t'(SMIN));
    endtask

    // long output stall while the input keeps offering beats
    task automatic test_output_hold();
        drain();
        set_gap(tmsf_pkg::GAP_RESET);
        src_idle_on = 1'b0;
        hold_len = 300;
        repeat (12) send_sample(sample_t'($urandom));
        drain();
        src_idle_on = 1'b1;
    endtask

    task automatic test_random();
        gap_t   g;
        longint g_l;
        longint span;
        longint level;
        longint dir;
        longint jmp;
        int     sent;
        int     n;
        level = 0;
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: g = tmsf_pkg::GAP_RESET;
                1: g = '0;
                2: g = GAP_MAX;
                3: g = gap_t'(1);
                4, 5: g = gap_t'($urandom_range(2, 1000));
                6: g = gap_t'($urandom);
                default: g = gap_t'($urandom_range(1000, 20000));
            endcase
            drain();
            set_gap(g);
            src_idle_on = (p != 3);
            snk_idle_on = (p != 3) && (p != 5);
            g_l = g;
            span = g_l / 2;
            if (span > 2000) span = 2000;
            if (span < 1) span = 1;
            sent = 0;
            while (sent < 95) begin
                case ($urandom_range(0, 3))
                    0, 1: begin
                        // settle on a level, then two jumps the same way
                        dir = $urandom_range(0, 1) ? 1 : -1;
                        if ($urandom_range(0, 3) == 0) level = sample_t'($urandom);
                        if (level + dir * 2 * (g_l + 8) > SMAX ||
                            level + dir * 2 * (g_l + 8) < SMIN) begin
                            level = (dir > 0) ? SMIN + span : SMAX - span;
                        end
                        n = $urandom_range(1, 4);
                        repeat (n) begin
                            send_sample(clamp_sample(level + jitter(span)));
                            sent++;
                        end
                        repeat (2) begin
                            jmp = ($urandom_range(0, 7) < 2) ? g_l - 1
                                                              : g_l + $urandom_range(0, 3);
                            level = clamp_sample(level + dir * jmp);
                            send_sample(sample_t'(level));
                            sent++;
                        end
                    end
                    2: begin
                        n = $urandom_range(1, 6);
                        repeat (n) begin
                            send_sample(clamp_sample(level + jitter(span)));
                            sent++;
                        end
                    end
                    default: begin
                        level = sample_t'($urandom);
                        send_sample(sample_t'(level));
                        sent++;
                    end
                endcase
            end
        end
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_sample    = '0;
        m_ready     = 1'b0;
        foreach (win_model[i]) win_model[i] = '0;
        next_slot = 0;
        gap_model = tmsf_pkg::GAP_RESET;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_threshold();
        test_extremes();
        test_output_hold();
        test_random();
        drain();
        $display("checked %0d results for %0d sample beats over %0d threshold writes",
                 results_seen, beats_sent, gap_writes);
        $display("%0d step refills seen, including a long output stall", steps_seen);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
